// File: src/ialu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ialu_pkg: shared types and constants for the integer ALU
// Opcode and status codes, default data width, pipeline bookkeeping.
// ----------------------------------------------------------------------------
package ialu_pkg;

    localparam int unsigned DefDataWidth = 32;
    localparam int unsigned OpWidth      = 5;
    localparam int unsigned StWidth      = 2;

    typedef enum logic [OpWidth-1:0] {
        OP_ADD  = 5'd0,
        OP_SUB  = 5'd1,
        OP_MUL  = 5'd2,
        OP_DIV  = 5'd3,
        OP_REM  = 5'd4,
        OP_AND  = 5'd5,
        OP_OR   = 5'd6,
        OP_XOR  = 5'd7,
        OP_ASR  = 5'd8,
        OP_LSL  = 5'd9,
        OP_LSR  = 5'd10,
        OP_EQ   = 5'd11,
        OP_NE   = 5'd12,
        OP_GT   = 5'd13,
        OP_GE   = 5'd14,
        OP_LT   = 5'd15,
        OP_LE   = 5'd16,
        OP_PASS = 5'd17
    } t_op;

    localparam logic [StWidth-1:0] ST_OK     = 2'd0;
    localparam logic [StWidth-1:0] ST_BAD_OP = 2'd1;
    localparam logic [StWidth-1:0] ST_DIV0   = 2'd2;

    // Item class, decided at entry and carried down the pipeline
    typedef enum logic [1:0] {
        K_SIMPLE = 2'd0,
        K_MUL    = 2'd1,
        K_DIV    = 2'd2,
        K_REM    = 2'd3
    } t_kind;

endpackage
`default_nettype wire

// File: src/ialu_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ialu_div: pipelined unsigned restoring divider
// One quotient bit per stage, DATA_WIDTH stages, shifts with a common enable.
// ----------------------------------------------------------------------------
module ialu_div
    import ialu_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = DefDataWidth
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [DATA_WIDTH-1:0] i_dividend,
    input  wire logic [DATA_WIDTH-1:0] i_divisor,
    output logic      [DATA_WIDTH-1:0] o_quot,
    output logic      [DATA_WIDTH-1:0] o_rem
);

    localparam int unsigned W = DATA_WIDTH;

    // per-stage partial remainder, remaining dividend bits/quotient, divisor
    logic [W-1:0] r_rem [W+1];
    logic [W-1:0] r_q   [W+1];
    logic [W-1:0] r_dsr [W+1];

    always_comb begin
        r_rem[0] = '0;
        r_q[0]   = i_dividend;
        r_dsr[0] = i_divisor;
    end

    for (genvar s = 0; s < W; s++) begin : g_stage
        logic [W:0]   w_trial;
        logic [W:0]   w_diff;
        logic [W-1:0] n_rem;
        logic [W-1:0] n_q;
        logic [W-1:0] r_rem_s;
        logic [W-1:0] r_q_s;
        logic [W-1:0] r_dsr_s;

        // one restoring step: shift in next dividend bit, try subtract
        always_comb begin
            w_trial = {r_rem[s], r_q[s][W-1]};
            w_diff  = w_trial - {1'b0, r_dsr[s]};
            if (!w_diff[W]) begin
                n_rem = w_diff[W-1:0];
                n_q   = {r_q[s][W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[W-1:0];
                n_q   = {r_q[s][W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem_s <= n_rem;
                r_q_s   <= n_q;
                r_dsr_s <= r_dsr[s];
            end
        end

        always_comb begin
            r_rem[s+1] = r_rem_s;
            r_q[s+1]   = r_q_s;
            r_dsr[s+1] = r_dsr_s;
        end
    end

    assign o_quot = r_q[W];
    assign o_rem  = r_rem[W];

endmodule
`default_nettype wire

// File: src/integer_alu_with_compare_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_alu_with_compare_core: pipelined 32-bit integer ALU with compares
// Add/sub/mul/div/rem, logic ops, shifts, signed compares, pass-through.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries opcode and two operands; output
//   channel o_valid/i_ready carries result and status. One result per item,
//   in order.
//   Pipeline: from input transfer to result an item passes one entry
//   stage, one divider stage per quotient bit, one fixup stage and the
//   output register.
//   Throughput: one item per cycle while the output is not stalled. All
//   items share one pipeline of fixed depth so results stay in order; the
//   multiplier uses three half-width partial products summed over two stages.
//   Stall: the whole pipeline advances together. While the output register
//   holds a result not yet taken, the pipeline freezes and o_ready is low;
//   empty bubbles stay where they are.
//   Reset: i_rst_n low synchronously clears all valid bits; payload
//   registers are not reset.
// ----------------------------------------------------------------------------
module integer_alu_with_compare_core
    import ialu_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = DefDataWidth
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [OpWidth-1:0]    i_opcode,
    input  wire logic [DATA_WIDTH-1:0] i_operand_a,
    input  wire logic [DATA_WIDTH-1:0] i_operand_b,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic      [DATA_WIDTH-1:0] o_result,
    output logic      [StWidth-1:0]    o_status
);

    localparam int unsigned W     = DATA_WIDTH;
    localparam int unsigned H     = (W + 1) / 2;
    localparam int unsigned SHW   = $clog2(W);
    // stages in r_vld: 1 entry, W divider, 1 fixup (output has its own valid)
    localparam int unsigned DEPTH = W + 2;

    typedef struct packed {
        t_kind                kind;
        logic                 neg_q;
        logic                 neg_r;
        logic [W-1:0]         val;
        logic [StWidth-1:0]   st;
    } t_tag;

    // ------------------------------------------------------------------
    // pipeline control: all stages advance when the output is free or moves
    // ------------------------------------------------------------------
    logic             r_out_valid;
    logic [DEPTH-1:0] r_vld;
    logic             w_adv;

    assign w_adv   = !r_out_valid || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_vld       <= {r_vld[DEPTH-2:0], i_valid};
            r_out_valid <= r_vld[DEPTH-1];
        end
    end

    // ------------------------------------------------------------------
    // entry decode: simple ops finish here, mul/div set up their operands
    // ------------------------------------------------------------------
    t_tag         n_tag;
    logic [W-1:0] w_mag_a;
    logic [W-1:0] w_mag_b;
    logic [SHW-1:0] w_sh;
    logic         w_lt;
    logic         w_gt;

    always_comb begin
        w_mag_a = i_operand_a[W-1] ? (~i_operand_a + 1'b1) : i_operand_a;
        w_mag_b = i_operand_b[W-1] ? (~i_operand_b + 1'b1) : i_operand_b;
        w_sh    = SHW'(i_operand_b % W);
        w_lt    = $signed(i_operand_a) < $signed(i_operand_b);
        w_gt    = $signed(i_operand_b) < $signed(i_operand_a);
    end

    always_comb begin
        n_tag       = '0;
        n_tag.kind  = K_SIMPLE;
        n_tag.st    = ST_OK;
        n_tag.neg_q = i_operand_a[W-1] ^ i_operand_b[W-1];
        n_tag.neg_r = i_operand_a[W-1];
        unique case (i_opcode)
            OP_ADD:  n_tag.val = i_operand_a + i_operand_b;
            OP_SUB:  n_tag.val = i_operand_a - i_operand_b;
            OP_MUL:  n_tag.kind = K_MUL;
            OP_DIV, OP_REM: begin
                n_tag.kind = (i_opcode == OP_DIV) ? K_DIV : K_REM;
                if (i_operand_b == '0) begin
                    n_tag.kind = K_SIMPLE;
                    n_tag.st   = ST_DIV0;
                end
            end
            OP_AND:  n_tag.val = i_operand_a & i_operand_b;
            OP_OR:   n_tag.val = i_operand_a | i_operand_b;
            OP_XOR:  n_tag.val = i_operand_a ^ i_operand_b;
            OP_ASR:  n_tag.val = W'($signed(i_operand_a) >>> w_sh);
            OP_LSL:  n_tag.val = i_operand_a << w_sh;
            OP_LSR:  n_tag.val = i_operand_a >> w_sh;
            OP_EQ:   n_tag.val = W'(i_operand_a == i_operand_b);
            OP_NE:   n_tag.val = W'(i_operand_a != i_operand_b);
            OP_GT:   n_tag.val = W'(w_gt);
            OP_GE:   n_tag.val = W'(!w_lt);
            OP_LT:   n_tag.val = W'(w_lt);
            OP_LE:   n_tag.val = W'(!w_gt);
            OP_PASS: n_tag.val = i_operand_a;
            default: n_tag.st  = ST_BAD_OP;
        endcase
    end

    // stage-0 registers
    t_tag         r_tag0;
    logic [W-1:0] r_ma;
    logic [W-1:0] r_mb;
    logic [W-1:0] r_a;
    logic [W-1:0] r_b;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tag0 <= n_tag;
            r_ma   <= w_mag_a;
            r_mb   <= w_mag_b;
            r_a    <= i_operand_a;
            r_b    <= i_operand_b;
        end
    end

    // ------------------------------------------------------------------
    // multiplier: three half-width products, then two summing stages
    // ------------------------------------------------------------------
    logic [W-1:0] r_pll;
    logic [W-1:0] r_plh;
    logic [W-1:0] r_phl;
    logic [W-1:0] r_mid;
    logic [W-1:0] r_mlo;
    logic [W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pll  <= W'(r_a[H-1:0] * r_b[H-1:0]);
            r_plh  <= W'(r_a[H-1:0] * r_b[W-1:H]);
            r_phl  <= W'(r_a[W-1:H] * r_b[H-1:0]);
            r_mid  <= r_plh + r_phl;
            r_mlo  <= r_pll;
            r_prod <= r_mlo + (r_mid << H);
        end
    end

    // product delay line to line up with the divider output
    // (product is ready at stage 3, divider output at stage W)
    logic [W-1:0] r_pdly [W-3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pdly[0] <= r_prod;
            for (int unsigned k = 1; k < W - 3; k++) begin
                r_pdly[k] <= r_pdly[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // divider and tag delay line
    // ------------------------------------------------------------------
    logic [W-1:0] w_quot;
    logic [W-1:0] w_rem;

    ialu_div #(
        .DATA_WIDTH(W)
    ) u_div (
        .i_clk      (i_clk),
        .i_en       (w_adv),
        .i_dividend (r_ma),
        .i_divisor  (r_mb),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    t_tag r_tdly [W];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tdly[0] <= r_tag0;
            for (int unsigned k = 1; k < W; k++) begin
                r_tdly[k] <= r_tdly[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // fixup: sign correction and result select
    // ------------------------------------------------------------------
    t_tag         w_t;
    logic [W-1:0] n_res;
    logic [W-1:0] r_res1;
    logic [StWidth-1:0] r_st1;

    assign w_t = r_tdly[W-1];

    always_comb begin
        unique case (w_t.kind)
            K_MUL:    n_res = r_pdly[W-4];
            K_DIV:    n_res = w_t.neg_q ? (~w_quot + 1'b1) : w_quot;
            K_REM:    n_res = w_t.neg_r ? (~w_rem + 1'b1) : w_rem;
            default:  n_res = w_t.val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res1 <= n_res;
            r_st1  <= w_t.st;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_result <= r_res1;
            o_status <= r_st1;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> (o_result == '0))
        else $error("error status with nonzero result");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_BAD_OP ||
                     o_status == ST_DIV0))
        else $error("status code out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result) && $stable(o_status))
        else $error("stalled result changed");

    a_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("pipeline moved during stall");

endmodule
`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for integer_alu_with_compare_core
// Drives opcode/operand items through the valid/ready input channel, predicts
// each result and status, and checks every output transfer in order against
// the predicted queue. Both sides idle at random; one phase holds the output
// off long enough to fill the pipeline and stall the input.
// ----------------------------------------------------------------------------
module tb;
    import ialu_pkg::*;

    localparam int W = 32;
    localparam int LATENCY = W + 2;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_valid = 1'b0;
    logic            o_ready;
    logic [OpWidth-1:0] i_opcode = '0;
    logic [W-1:0]    i_operand_a = '0;
    logic [W-1:0]    i_operand_b = '0;
    logic            o_valid;
    logic            i_ready = 1'b0;
    logic [W-1:0]    o_result;
    logic [StWidth-1:0] o_status;

    typedef struct packed {
        logic [W-1:0]       result;
        logic [StWidth-1:0] status;
    } t_alu_out;

    t_alu_out    expected_q[$];
    int          error_count = 0;
    int          item_count = 0;
    int          result_count = 0;
    int          hold_cycles = 0;   // long receiver hold-off when nonzero
    int          sink_wait = 0;     // receiver idle cycles left before next transfer
    bit          sink_random = 1'b1;

    integer_alu_with_compare_core #(.DATA_WIDTH(W)) dut (.*);

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 0;
    end

    // Predict one transfer's result
    function automatic t_alu_out alu_predict(logic [4:0] op, logic [W-1:0] a, logic [W-1:0] b);
        t_alu_out   o;
        logic [4:0] sh;
        logic [W-1:0] ma, mb, q, m;
        o.result = '0;
        o.status = ST_OK;
        sh = b[4:0];
        ma = a[W-1] ? -a : a;
        mb = b[W-1] ? -b : b;
        case (op)
            OP_ADD:  o.result = a + b;
            OP_SUB:  o.result = a - b;
            OP_MUL:  o.result = a * b;
            OP_DIV, OP_REM: begin
                if (b == '0) begin
                    o.status = ST_DIV0;
                end else begin
                    q = ma / mb;
                    m = ma % mb;
                    if (op == OP_DIV) o.result = (a[W-1] ^ b[W-1]) ? -q : q;
                    else              o.result = a[W-1] ? -m : m;
                end
            end
            OP_AND:  o.result = a & b;
            OP_OR:   o.result = a | b;
            OP_XOR:  o.result = a ^ b;
            OP_ASR:  o.result = $signed(a) >>> sh;
            OP_LSL:  o.result = a << sh;
            OP_LSR:  o.result = a >> sh;
            OP_EQ:   o.result = W'(a == b);
            OP_NE:   o.result = W'(a != b);
            OP_GT:   o.result = W'($signed(a) > $signed(b));
            OP_GE:   o.result = W'($signed(a) >= $signed(b));
            OP_LT:   o.result = W'($signed(a) < $signed(b));
            OP_LE:   o.result = W'($signed(a) <= $signed(b));
            OP_PASS: o.result = a;
            default: o.status = ST_BAD_OP;
        endcase
        return o;
    endfunction

    // Append one prediction to the tail of the expected queue
    task automatic queue_expected(t_alu_out e);
        expected_q.insert(expected_q.size(), e);
    endtask

    task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
        error_count++;
        $display("MISMATCH %s: got %h expected %h (result #%0d)", what, got, want,
                 result_count);
    endtask

    // Send one item; idle a random gap first (valid stays high on no gap)
    task automatic send_item(logic [4:0] op, logic [W-1:0] a, logic [W-1:0] b);
        int gap;
        gap = $urandom_range(0, 2) == 0 ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_opcode    <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        queue_expected(alu_predict(op, a, b));
        do @(posedge i_clk); while (!o_ready);
        item_count++;
    endtask

    // Receiver ready control: a drawn idle count after each transfer
    always @(posedge i_clk) begin
        int draw;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            i_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (sink_random) begin
            if (sink_wait > 0) begin
                i_ready   <= 1'b0;
                sink_wait <= sink_wait - 1;
            end else if (o_valid && i_ready) begin
                draw = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 14) : 0;
                i_ready   <= (draw == 0);
                sink_wait <= (draw == 0) ? 0 : draw - 1;
            end else begin
                i_ready <= 1'b1;
            end
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Check each output transfer
    always @(posedge i_clk) begin
        t_alu_out want;
        if (i_rst_n && o_valid && i_ready) begin
            result_count++;
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result", o_result, '0);
            end else begin
                want = expected_q.pop_front();
                if (o_result !== want.result) report_mismatch("result", o_result, want.result);
                if (o_status !== want.status)
                    report_mismatch("status", W'(o_status), W'(want.status));
            end
        end
    end

    function automatic logic [W-1:0] rand_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(0, 8)) - 4);
            3: return 32'($urandom_range(0, 255));
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed();
        send_item(OP_ADD, 32'h7fff_ffff, 32'h1);
        send_item(OP_SUB, 32'h8000_0000, 32'h1);
        send_item(OP_MUL, 32'h8000_0000, 32'hffff_ffff);
        send_item(OP_MUL, 32'hffff_ffff, 32'hffff_ffff);
        send_item(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_item(OP_REM, 32'h8000_0000, 32'hffff_ffff);
        send_item(OP_DIV, 32'h1234, 32'h0);
        send_item(OP_REM, 32'hffff_fff9, 32'h0);
        send_item(OP_DIV, 32'hffff_fff9, 32'h2);
        send_item(OP_REM, 32'hffff_fff9, 32'h2);
        send_item(OP_AND, 32'hffff_ffff, 32'ha5a5_5a5a);
        send_item(OP_OR,  32'h0, 32'h8000_0001);
        send_item(OP_XOR, 32'hffff_ffff, 32'h0f0f_0f0f);
        send_item(OP_ASR, 32'h8000_0000, 32'd31);
        send_item(OP_ASR, 32'h8000_0000, 32'hffff_ffe1);
        send_item(OP_LSL, 32'hffff_ffff, 32'd63);
        send_item(OP_LSR, 32'h8000_0000, 32'd32);
        send_item(OP_EQ,  32'h8000_0000, 32'h8000_0000);
        send_item(OP_NE,  32'h8000_0000, 32'h7fff_ffff);
        send_item(OP_GT,  32'h7fff_ffff, 32'h8000_0000);
        send_item(OP_GE,  32'h5, 32'h5);
        send_item(OP_LT,  32'h8000_0000, 32'h7fff_ffff);
        send_item(OP_LE,  32'h7fff_ffff, 32'h7fff_ffff);
        send_item(OP_PASS, 32'hdead_beef, 32'h0);
        send_item(5'd31, 32'hffff_ffff, 32'hffff_ffff);
        send_item(5'd18, 32'h1, 32'h1);
    endtask

    task automatic test_random(int n);
        logic [4:0] op;
        repeat (n) begin
            op = ($urandom_range(0, 9) == 0) ? 5'($urandom()) : 5'($urandom_range(0, 17));
            send_item(op, rand_operand(), rand_operand());
        end
    endtask

    // Hold the receiver off while items keep coming, so the input stalls
    task automatic test_backpressure();
        hold_cycles = 120;
        test_random(80);
    endtask

    task automatic test_full_rate();
        sink_random = 1'b0;
        fork
            begin
                repeat (150) begin
                    i_valid     <= 1'b1;
                    i_opcode    <= 5'($urandom_range(0, 17));
                    i_operand_a <= $urandom();
                    i_operand_b <= $urandom();
                    @(posedge i_clk);
                    while (!o_ready) @(posedge i_clk);
                    queue_expected(alu_predict(i_opcode, i_operand_a, i_operand_b));
                    item_count++;
                end
            end
        join
        sink_random = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(400);
        test_backpressure();
        test_full_rate();
        test_random(400);
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Covered %0d items over all opcodes, operand extremes, divide by zero,",
                 item_count);
        $display("unknown opcodes, full rate and a long output stall; %0d results checked.",
                 result_count);
        if (error_count == 0 && expected_q.size() == 0) begin
            $display("integer_alu_with_compare_core test passed");
        end else begin
            $display("integer_alu_with_compare_core test failed");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("integer_alu_with_compare_core test failed");
        $finish;
    end
endmodule
